/* hdl/afrb_pkg.sv */
`default_nettype none
package afrb_pkg;

	// default geometry of the frame ring
	localparam int FRAME_SAMPLES_DEF = 160;
	localparam int NUM_FRAMES_DEF    = 4;

	// fixed field widths
	localparam int SAMPLE_W    = 16;
	localparam int INDEX_W     = 8;
	localparam int KIND_W      = 2;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	// request kinds carried on the input tuser
	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH    = 2'd0,
		KIND_READ    = 2'd1,
		KIND_RELEASE = 2'd2
	} kind_t;

	// result word on the output tdata, lowest bit last
	typedef struct packed {
		logic [2:0]                 pad;
		logic                       release_done;
		logic                       resume_event;
		logic                       drop_event;
		logic                       sample_stored;
		logic                       frame_available;
		logic signed [SAMPLE_W-1:0] read_data;
	} out_word_t;

endpackage
`default_nettype wire

/* hdl/afrb_frame_mem.sv */
`default_nettype none
module afrb_frame_mem #(
	parameter int DEPTH  = afrb_pkg::FRAME_SAMPLES_DEF * afrb_pkg::NUM_FRAMES_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic                                 clk,
	input  wire logic                                 wr_en,
	input  wire logic [ADDR_W-1:0]                    wr_addr,
	input  wire logic signed [afrb_pkg::SAMPLE_W-1:0] wr_data,
	input  wire logic                                 rd_en,
	input  wire logic [ADDR_W-1:0]                    rd_addr,
	output logic signed [afrb_pkg::SAMPLE_W-1:0]      rd_data
);
	import afrb_pkg::*;

	logic signed [SAMPLE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port, holds while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

/* hdl/audio_frame_ring_buffer.sv */
// an accepted transaction is held in the input register, then its result in the result register
// throughput: one transaction per cycle while the output is not stalled; each item
//   updates the ring state and makes at most one frame memory write or one registered read
// reset: arst_n clears the pipeline valids and ring pointers, drop state set;
//   the frame memory is not cleared and needs no clearing pass
`default_nettype none
module audio_frame_ring_buffer #(
	parameter int FRAME_SAMPLES = afrb_pkg::FRAME_SAMPLES_DEF,
	parameter int NUM_FRAMES    = afrb_pkg::NUM_FRAMES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	// sample[15:0], read_index[23:16]
	input  wire logic [afrb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// kind[1:0]
	input  wire logic [afrb_pkg::KIND_W-1:0]         s_axis_tuser,
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	// read_data[15:0], frame_available[16], sample_stored[17], drop_event[18],
	// resume_event[19], release_done[20], zero fill[23:21]
	output logic [afrb_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);
	import afrb_pkg::*;

	localparam int STORE_WORDS = FRAME_SAMPLES * NUM_FRAMES;
	localparam int ADDR_W      = $clog2(STORE_WORDS);
	localparam int SLOT_W      = $clog2(NUM_FRAMES);
	localparam int CNT_W       = $clog2(NUM_FRAMES + 1);
	localparam int SUM_W       = $clog2(2 * NUM_FRAMES);
	localparam int POS_W       = $clog2(FRAME_SAMPLES);

	localparam logic [CNT_W-1:0]  NUM_C       = CNT_W'(NUM_FRAMES);
	localparam logic [SUM_W-1:0]  NUM_SUM_C   = SUM_W'(NUM_FRAMES);
	localparam logic [SLOT_W-1:0] LAST_SLOT_C = SLOT_W'(NUM_FRAMES - 1);
	localparam logic [POS_W-1:0]  LAST_POS_C  = POS_W'(FRAME_SAMPLES - 1);
	localparam logic [ADDR_W-1:0] FRAME_C     = ADDR_W'(FRAME_SAMPLES);

	// input stage
	logic                       valid_s1;
	logic [KIND_W-1:0]          kind_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic [INDEX_W-1:0]         ridx_s1;

	// result stage
	logic valid_s2;
	logic avail_s2;
	logic stored_s2;
	logic drop_s2;
	logic resume_s2;
	logic rel_s2;
	logic rdok_s2;

	// ring state
	logic [SLOT_W-1:0] head_q;
	logic [CNT_W-1:0]  used_q;
	logic [POS_W-1:0]  wpos_q;
	logic              open_q;
	logic              drop_q;

	logic [SLOT_W-1:0] nx_head;
	logic [CNT_W-1:0]  nx_used;
	logic [POS_W-1:0]  nx_wpos;
	logic              nx_open;
	logic              nx_drop;

	logic stored;
	logic drop_ev;
	logic res_ev;
	logic rel;
	logic rd_ok;

	logic [SUM_W-1:0]  open_sum;
	logic [SLOT_W-1:0] wslot;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic signed [SAMPLE_W-1:0] rdata;

	logic adv2;
	logic fire1;
	logic s_accept;
	out_word_t ow;

	// handshake: the result register frees the input stage
	assign adv2          = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv2;
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign fire1         = valid_s1 && adv2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			kind_s1   <= s_axis_tuser;
			sample_s1 <= s_axis_tdata[SAMPLE_W-1:0];
			ridx_s1   <= s_axis_tdata[SAMPLE_W +: INDEX_W];
		end
	end

	// ring update for the item in the input stage
	always_comb begin
		nx_head  = head_q;
		nx_used  = used_q;
		nx_wpos  = wpos_q;
		nx_open  = open_q;
		nx_drop  = drop_q;
		stored   = 1'b0;
		drop_ev  = 1'b0;
		res_ev   = 1'b0;
		rel      = 1'b0;
		rd_ok    = 1'b0;
		wr_en    = 1'b0;
		open_sum = '0;
		wslot    = '0;
		wr_addr  = '0;
		rd_addr  = '0;
		unique case (kind_s1)
			KIND_PUSH: begin
				// claim a slot when no frame is open
				if (!nx_open) begin
					if (nx_used < NUM_C) begin
						res_ev  = nx_drop;
						nx_drop = 1'b0;
						nx_used = nx_used + CNT_W'(1);
						nx_open = 1'b1;
					end else begin
						drop_ev = !nx_drop;
						nx_drop = 1'b1;
						nx_open = 1'b0;
					end
				end
				if (nx_open) begin
					// open slot is head + used - 1 modulo the ring size
					open_sum = SUM_W'(head_q) + SUM_W'(nx_used) - SUM_W'(1);
					if (open_sum >= NUM_SUM_C) begin
						open_sum = open_sum - NUM_SUM_C;
					end
					wslot   = SLOT_W'(open_sum);
					wr_addr = ADDR_W'(wslot) * FRAME_C + ADDR_W'(wpos_q);
					wr_en   = 1'b1;
					stored  = 1'b1;
					if (wpos_q == LAST_POS_C) begin
						// frame full: close it and claim the next slot
						nx_wpos = '0;
						if (nx_used < NUM_C) begin
							res_ev  = nx_drop;
							nx_drop = 1'b0;
							nx_used = nx_used + CNT_W'(1);
							nx_open = 1'b1;
						end else begin
							drop_ev = !nx_drop;
							nx_drop = 1'b1;
							nx_open = 1'b0;
						end
					end else begin
						nx_wpos = wpos_q + POS_W'(1);
					end
				end
			end
			KIND_READ: begin
				if (used_q > CNT_W'(1) && int'(ridx_s1) < FRAME_SAMPLES) begin
					rd_ok   = 1'b1;
					rd_addr = ADDR_W'(head_q) * FRAME_C + ADDR_W'(ridx_s1);
				end
			end
			KIND_RELEASE: begin
				if (used_q > CNT_W'(1)) begin
					nx_head = (head_q == LAST_SLOT_C) ? '0 : head_q + SLOT_W'(1);
					nx_used = used_q - CNT_W'(1);
					rel     = 1'b1;
				end
			end
			default: begin
				// unused kind leaves the ring as it is
			end
		endcase
	end

	// ring state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			used_q <= '0;
			wpos_q <= '0;
			open_q <= 1'b0;
			drop_q <= 1'b1;
		end else if (fire1) begin
			head_q <= nx_head;
			used_q <= nx_used;
			wpos_q <= nx_wpos;
			open_q <= nx_open;
			drop_q <= nx_drop;
		end
	end

	// frame storage
	afrb_frame_mem #(
		.DEPTH  (STORE_WORDS),
		.ADDR_W (ADDR_W)
	) u_frame_mem (
		.clk     (clk),
		.wr_en   (fire1 && wr_en),
		.wr_addr (wr_addr),
		.wr_data (sample_s1),
		.rd_en   (fire1 && rd_ok),
		.rd_addr (rd_addr),
		.rd_data (rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			avail_s2  <= nx_used > CNT_W'(1);
			stored_s2 <= stored;
			drop_s2   <= drop_ev;
			resume_s2 <= res_ev;
			rel_s2    <= rel;
			rdok_s2   <= rd_ok;
		end
	end

	// output word
	always_comb begin
		ow                 = '0;
		ow.read_data       = rdok_s2 ? rdata : '0;
		ow.frame_available = avail_s2;
		ow.sample_stored   = stored_s2;
		ow.drop_event      = drop_s2;
		ow.resume_event    = resume_s2;
		ow.release_done    = rel_s2;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = ow;

endmodule
`default_nettype wire

/* hdl/afrb_checker.sv */
`default_nettype none
module afrb_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              m_axis_tvalid,
	input wire logic                              m_axis_tready,
	input wire logic [afrb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import afrb_pkg::*;

	out_word_t ow;
	assign ow = m_axis_tdata;

	// a stalled result holds its value
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// one claim per push cannot both drop and resume
	a_event_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(ow.drop_event && ow.resume_event))
		else $error("drop and resume in one result");

	// a resume always comes with a stored sample
	a_resume_store: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ow.resume_event |-> ow.sample_stored)
		else $error("resume without stored sample");

	// a push result carries no read word and no release
	a_push_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ow.sample_stored |-> ow.read_data == '0 && !ow.release_done)
		else $error("push result mixed with read or release");

endmodule

bind audio_frame_ring_buffer afrb_checker u_afrb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

/* tb/tb_audio_frame_ring_buffer.sv */
`timescale 1ns / 1ps
module tb_audio_frame_ring_buffer;
	import afrb_pkg::*;

	localparam int FRAME_LEN   = FRAME_SAMPLES_DEF;
	localparam int RING_SLOTS  = NUM_FRAMES_DEF;
	localparam int RANDOM_ITEMS = 450;
	localparam int QUIET_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [KIND_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// expected result words in transaction order
	out_word_t awaited_words[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	int out_stall = 0;
	bit idle_on = 1'b1;

	// shadow of the ring state
	logic [SAMPLE_W-1:0] ring_mem [RING_SLOTS*FRAME_LEN];
	int unsigned oldest_slot = 0;
	int unsigned slots_held = 0;
	int unsigned fill_pos = 0;
	bit frame_filling = 1'b0;
	bit ring_overrun = 1'b1;

	audio_frame_ring_buffer DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int idle_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// random sample word
	function automatic logic [SAMPLE_W-1:0] rnd_sample();
		return SAMPLE_W'($urandom);
	endfunction

	// random read index within a range
	function automatic logic [INDEX_W-1:0] rnd_index(int unsigned lo, int unsigned hi);
		return INDEX_W'($urandom_range(lo, hi));
	endfunction

	// claim the next free slot, raising drop or resume with hysteresis
	function automatic void claim_slot(inout out_word_t r);
		if (slots_held < RING_SLOTS) begin
			if (ring_overrun) begin
				r.resume_event = 1'b1;
				ring_overrun = 1'b0;
			end
			slots_held++;
			frame_filling = 1'b1;
		end else begin
			if (!ring_overrun) begin
				r.drop_event = 1'b1;
				ring_overrun = 1'b1;
			end
			frame_filling = 1'b0;
		end
	endfunction

	// apply one transaction to the shadow ring and return the result word
	function automatic out_word_t ring_apply(logic [KIND_W-1:0] kind,
			logic [SAMPLE_W-1:0] sample, logic [INDEX_W-1:0] idx);
		out_word_t r;
		int unsigned slot;
		r = '0;
		case (kind)
			KIND_PUSH: begin
				if (!frame_filling)
					claim_slot(r);
				if (frame_filling) begin
					slot = (oldest_slot + slots_held + RING_SLOTS - 1) % RING_SLOTS;
					ring_mem[slot*FRAME_LEN + fill_pos] = sample;
					r.sample_stored = 1'b1;
					fill_pos++;
					if (fill_pos >= FRAME_LEN) begin
						fill_pos = 0;
						claim_slot(r);
					end
				end
			end
			KIND_READ: begin
				if (slots_held > 1 && idx < FRAME_LEN)
					r.read_data = ring_mem[oldest_slot*FRAME_LEN + idx];
			end
			KIND_RELEASE: begin
				if (slots_held > 1) begin
					oldest_slot = (oldest_slot + 1) % RING_SLOTS;
					slots_held--;
					r.release_done = 1'b1;
				end
			end
			default: ;
		endcase
		r.frame_available = (slots_held > 1);
		return r;
	endfunction

	function automatic string word_text(out_word_t w);
		return $sformatf("data=%0d avail=%0b stored=%0b drop=%0b resume=%0b rel=%0b pad=%0h",
			w.read_data, w.frame_available, w.sample_stored, w.drop_event,
			w.resume_event, w.release_done, w.pad);
	endfunction

	// one input transaction, with a random gap ahead of it
	task automatic send_item(input logic [KIND_W-1:0] kind,
			input logic [SAMPLE_W-1:0] sample, input logic [INDEX_W-1:0] idx);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {idx, sample};
		s_axis_tuser <= kind;
		do
			@(posedge clk);
		while (!s_axis_tready);
		awaited_words.push_back(ring_apply(kind, sample, idx));
	endtask

	// nothing readable yet: read, release and unused kind on an empty ring
	task automatic test_empty_ring;
		send_item(KIND_READ, rnd_sample(), 8'd0);
		send_item(KIND_RELEASE, rnd_sample(), rnd_index(0, 255));
		send_item(KIND_UNUSED, rnd_sample(), rnd_index(0, 255));
		send_item(KIND_READ, rnd_sample(), 8'hFF);
	endtask

	// sample extremes and bit patterns, first one resumes the producer
	task automatic test_sample_extremes;
		send_item(KIND_PUSH, 16'h8000, 8'h00);
		send_item(KIND_PUSH, 16'h7FFF, 8'hFF);
		send_item(KIND_PUSH, 16'h0000, rnd_index(0, 255));
		send_item(KIND_PUSH, 16'hFFFF, rnd_index(0, 255));
		send_item(KIND_PUSH, 16'h5555, rnd_index(0, 255));
		send_item(KIND_PUSH, 16'hAAAA, rnd_index(0, 255));
	endtask

	// fill every slot until samples drop, then drain and resume
	task automatic test_overrun_recovery;
		while (!ring_overrun)
			send_item(KIND_PUSH, rnd_sample(), rnd_index(0, 255));
		repeat (3) send_item(KIND_PUSH, rnd_sample(), rnd_index(0, 255));
		send_item(KIND_READ, rnd_sample(), 8'd0);
		send_item(KIND_READ, rnd_sample(), INDEX_W'(FRAME_LEN - 1));
		send_item(KIND_READ, rnd_sample(), INDEX_W'(FRAME_LEN));
		send_item(KIND_READ, rnd_sample(), 8'hFF);
		send_item(KIND_READ, rnd_sample(), rnd_index(0, FRAME_LEN - 1));
		send_item(KIND_RELEASE, rnd_sample(), rnd_index(0, 255));
		send_item(KIND_PUSH, rnd_sample(), rnd_index(0, 255));
		while (slots_held > 1)
			send_item(KIND_RELEASE, rnd_sample(), rnd_index(0, 255));
		send_item(KIND_RELEASE, rnd_sample(), rnd_index(0, 255));
		send_item(KIND_UNUSED, rnd_sample(), rnd_index(0, 255));
	endtask

	// bursts of producer and consumer traffic with random content
	task automatic test_random_traffic;
		int sent;
		int mode;
		int len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			mode = $urandom_range(0, 9);
			if (mode <= 4) begin
				len = $urandom_range(1, 200);
				repeat (len) send_item(KIND_PUSH, rnd_sample(), rnd_index(0, 255));
			end else if (mode <= 6) begin
				len = $urandom_range(1, 20);
				repeat (len) begin
					if ($urandom_range(0, 7) == 0)
						send_item(KIND_READ, rnd_sample(), rnd_index(FRAME_LEN, 255));
					else
						send_item(KIND_READ, rnd_sample(), rnd_index(0, FRAME_LEN - 1));
				end
			end else if (mode == 7) begin
				len = $urandom_range(1, 2);
				repeat (len) send_item(KIND_RELEASE, rnd_sample(), rnd_index(0, 255));
			end else if (mode == 8) begin
				len = $urandom_range(1, 10);
				repeat (len) send_item(KIND_W'($urandom_range(0, 3)), rnd_sample(),
					rnd_index(0, 255));
			end else begin
				len = 9;
				repeat (8) send_item(KIND_READ, rnd_sample(), rnd_index(0, FRAME_LEN - 1));
				send_item(KIND_RELEASE, rnd_sample(), rnd_index(0, 255));
			end
			sent += len;
		end
		idle_on = 1'b1;
	endtask

	// result checker and random receiver stalls
	always @(posedge clk) begin : result_check
		out_word_t got;
		out_word_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = out_word_t'(m_axis_tdata);
			if (awaited_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: %s", word_text(got));
			end else begin
				want = awaited_words.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %s, got %s",
							word_text(want), word_text(got));
				end
			end
		end
		if (out_stall > 0) begin
			m_axis_tready <= 1'b0;
			out_stall--;
		end else begin
			out_stall = idle_gap();
			m_axis_tready <= (out_stall == 0);
			if (out_stall > 0)
				out_stall--;
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		foreach (ring_mem[i])
			ring_mem[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_ring();
		test_sample_extremes();
		test_overrun_recovery();
		test_random_traffic();
		s_axis_tvalid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && awaited_words.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
